### src/mbbs_pkg.sv
// shared types and constants of the mask block bit spender
package mbbs_pkg;

  localparam int WORD_W            = 32;
  localparam int CFG_W             = 5;
  localparam int CNT_W             = 5;
  localparam int BITS_W            = 6;
  localparam int BYTES_W           = 3;
  localparam int DEF_MAX_BLK_WORDS = 16;

  localparam logic [BITS_W-1:0]  RES_BITS     = 6'd32;
  localparam logic [BYTES_W-1:0] RES_BYTES    = 3'd4;
  localparam logic [CFG_W-1:0]   RST_BLK_WORDS = 5'd8;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_BITS = 2'd1,
    KIND_BYTE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_MANY = 2'd1,
    ST_NO_BLOCK = 2'd2,
    ST_REJECTED = 2'd3
  } status_e;

  // what the reservoir stage has to do with the transaction
  typedef enum logic [2:0] {
    OP_NONE,
    OP_BITS_HIT,
    OP_BITS_DRAW,
    OP_BITS_LOSE,
    OP_BYTE_HIT,
    OP_BYTE_DRAW
  } op_e;

  typedef struct packed {
    op_e               op;
    status_e           status;
    logic [BITS_W-1:0] keep;   // bits left in the reservoir afterwards
    logic [1:0]        sel;    // byte lane for a byte hit
  } s2_op_t;

endpackage

### src/mbbs_store.sv
// block word store: one write port, one registered read port
module mbbs_store #(
  parameter int Depth = mbbs_pkg::DEF_MAX_BLK_WORDS,
  parameter int AddrW = 4
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AddrW-1:0]            waddr_i,
  input  logic [mbbs_pkg::WORD_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AddrW-1:0]            raddr_i,
  output logic [mbbs_pkg::WORD_W-1:0] rdata_o
);
  import mbbs_pkg::*;

  logic [WORD_W-1:0] mem [Depth];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/mbbs_ctrl.sv
// decode and counter state: block fill, word draw and reservoir fill levels
module mbbs_ctrl #(
  parameter int MaxWords = mbbs_pkg::DEF_MAX_BLK_WORDS,
  parameter int AddrW    = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        acc_i,
  input  logic [1:0]                  kind_i,
  input  logic [mbbs_pkg::BITS_W-1:0] need_i,
  input  logic [mbbs_pkg::WORD_W-1:0] word_i,
  input  logic                        cfg_we_i,
  input  logic [mbbs_pkg::CFG_W-1:0]  cfg_wdata_i,
  output mbbs_pkg::s2_op_t            op_o,
  output logic                        mem_we_o,
  output logic [AddrW-1:0]            mem_waddr_o,
  output logic [mbbs_pkg::WORD_W-1:0] mem_wdata_o,
  output logic                        mem_re_o,
  output logic [AddrW-1:0]            mem_raddr_o
);
  import mbbs_pkg::*;

  logic [CFG_W-1:0]   block_words_q, block_words_d;
  logic [CNT_W-1:0]   words_left_q, words_left_d;
  logic [CNT_W-1:0]   fill_count_q, fill_count_d;
  logic [BITS_W-1:0]  bit_lvl_q, bit_lvl_d;
  logic [BYTES_W-1:0] byte_lvl_q, byte_lvl_d;

  logic [CNT_W-1:0] bw;
  logic             avail;
  logic [CNT_W-1:0] fill_sel;
  logic [CNT_W-1:0] fill_inc;
  logic [CNT_W-1:0] draw_idx;

  always_comb begin
    if (block_words_q == '0) begin
      bw = CNT_W'(1);
    end else if (32'(block_words_q) > 32'(MaxWords)) begin
      bw = CNT_W'(MaxWords);
    end else begin
      bw = block_words_q;
    end
  end

  assign avail    = (words_left_q != '0) && (words_left_q <= bw);
  assign fill_sel = (fill_count_q >= bw) ? '0 : fill_count_q;
  assign fill_inc = fill_sel + CNT_W'(1);
  assign draw_idx = bw - words_left_q;

  assign mem_waddr_o = AddrW'(fill_sel);
  assign mem_wdata_o = word_i;
  assign mem_raddr_o = AddrW'(draw_idx);

  always_comb begin
    block_words_d = block_words_q;
    words_left_d  = words_left_q;
    fill_count_d  = fill_count_q;
    bit_lvl_d     = bit_lvl_q;
    byte_lvl_d    = byte_lvl_q;
    op_o          = '{op: OP_NONE, status: ST_OK, keep: '0, sel: '0};
    mem_we_o      = 1'b0;
    mem_re_o      = 1'b0;

    case (kind_i)
      KIND_LOAD: begin
        if (words_left_q != '0) begin
          op_o.status = ST_REJECTED;
        end else begin
          mem_we_o = acc_i;
          if (fill_inc >= bw) begin
            words_left_d = bw;
            fill_count_d = '0;
          end else begin
            fill_count_d = fill_inc;
          end
        end
      end
      KIND_BITS: begin
        if (need_i > RES_BITS) begin
          op_o.status = ST_TOO_MANY;
        end else if (need_i == '0) begin
          op_o.op = OP_NONE;
        end else if (need_i <= bit_lvl_q) begin
          op_o.op   = OP_BITS_HIT;
          op_o.keep = bit_lvl_q - need_i;
          bit_lvl_d = bit_lvl_q - need_i;
        end else if (avail) begin
          // remainder spans into the next block word
          op_o.op      = OP_BITS_DRAW;
          op_o.keep    = RES_BITS - need_i + bit_lvl_q;
          bit_lvl_d    = RES_BITS - need_i + bit_lvl_q;
          words_left_d = words_left_q - CNT_W'(1);
          mem_re_o     = acc_i;
        end else begin
          // leftover bits are discarded, not returned, and the result is zero
          op_o.op     = OP_BITS_LOSE;
          op_o.status = ST_NO_BLOCK;
          bit_lvl_d   = '0;
        end
      end
      KIND_BYTE: begin
        if (byte_lvl_q == '0 || byte_lvl_q > RES_BYTES) begin
          if (avail) begin
            op_o.op      = OP_BYTE_DRAW;
            byte_lvl_d   = RES_BYTES - BYTES_W'(1);
            words_left_d = words_left_q - CNT_W'(1);
            mem_re_o     = acc_i;
          end else begin
            op_o.status = ST_NO_BLOCK;
          end
        end else begin
          op_o.op    = OP_BYTE_HIT;
          op_o.sel   = 2'(byte_lvl_q - BYTES_W'(1));
          byte_lvl_d = byte_lvl_q - BYTES_W'(1);
        end
      end
      default: begin
        op_o.op = OP_NONE;
      end
    endcase

    if (!acc_i) begin
      words_left_d = words_left_q;
      fill_count_d = fill_count_q;
      bit_lvl_d    = bit_lvl_q;
      byte_lvl_d   = byte_lvl_q;
    end

    if (cfg_we_i) begin
      block_words_d = cfg_wdata_i;
      words_left_d  = '0;
      fill_count_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_words_q <= RST_BLK_WORDS;
      words_left_q  <= '0;
      fill_count_q  <= '0;
      bit_lvl_q     <= '0;
      byte_lvl_q    <= '0;
    end else begin
      block_words_q <= block_words_d;
      words_left_q  <= words_left_d;
      fill_count_q  <= fill_count_d;
      bit_lvl_q     <= bit_lvl_d;
      byte_lvl_q    <= byte_lvl_d;
    end
  end

`ifndef ASSERT_OFF
  a_words_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    words_left_q <= bw)
    else $error("words_left beyond block size");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_count_q < bw)
    else $error("fill count not below block size");

  a_load_draw_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we_o && mem_re_o))
    else $error("store written and drawn in one transaction");

  a_draw_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_re_o && !cfg_we_i) |=> words_left_q == $past(words_left_q) - CNT_W'(1))
    else $error("draw did not consume a word");

  a_res_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_lvl_q <= RES_BITS && byte_lvl_q <= RES_BYTES)
    else $error("reservoir fill level out of range");
`endif

endmodule

### src/mbbs_drain.sv
// reservoir data stage and output register
module mbbs_drain (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        acc_i,
  input  mbbs_pkg::s2_op_t            op_i,
  input  logic [mbbs_pkg::WORD_W-1:0] rdata_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mbbs_pkg::WORD_W-1:0] out_value_o,
  output mbbs_pkg::status_e           out_status_o
);
  import mbbs_pkg::*;

  logic              s2_valid_q;
  s2_op_t            s2_op_q;
  logic              s2_move;
  logic [WORD_W-1:0] bit_res_q, bit_res_d;
  logic [WORD_W-1:0] byte_res_q, byte_res_d;
  logic [WORD_W-1:0] keep_mask;
  logic [WORD_W-1:0] value;
  logic              out_valid_q;
  logic [WORD_W-1:0] out_value_q;
  status_e           out_status_q;

  assign s2_move    = s2_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s2_valid_q || s2_move;
  assign keep_mask  = ~({WORD_W{1'b1}} << s2_op_q.keep);

  always_comb begin
    value      = '0;
    bit_res_d  = bit_res_q;
    byte_res_d = byte_res_q;
    case (s2_op_q.op)
      OP_BITS_HIT: begin
        value     = bit_res_q >> s2_op_q.keep;
        bit_res_d = bit_res_q & keep_mask;
      end
      OP_BITS_DRAW: begin
        // old reservoir bits on top, fresh word below
        value     = WORD_W'({bit_res_q, rdata_i} >> s2_op_q.keep);
        bit_res_d = rdata_i & keep_mask;
      end
      OP_BITS_LOSE: begin
        bit_res_d = '0;
      end
      OP_BYTE_HIT: begin
        value = {24'd0, byte_res_q[{s2_op_q.sel, 3'b000} +: 8]};
      end
      OP_BYTE_DRAW: begin
        value      = {24'd0, rdata_i[31:24]};
        byte_res_d = rdata_i;
      end
      default: begin
        value = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      bit_res_q   <= '0;
      byte_res_q  <= '0;
    end else begin
      if (acc_i) begin
        s2_valid_q <= 1'b1;
      end else if (s2_move) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_move) begin
        out_valid_q <= 1'b1;
        bit_res_q   <= bit_res_d;
        byte_res_q  <= byte_res_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s2_op_q <= op_i;
    end
    if (s2_move) begin
      out_value_q  <= value;
      out_status_q <= s2_op_q.status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;

`ifndef ASSERT_OFF
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !s2_move) |=> (s2_valid_q && $stable(s2_op_q)))
    else $error("stalled transaction changed in reservoir stage");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i |-> (!s2_valid_q || s2_move))
    else $error("transaction accepted over a held one");

  a_res_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_move && s2_op_q.op == OP_BITS_LOSE) |=> bit_res_q == '0)
    else $error("bit reservoir not cleared after lost draw");
`endif

endmodule

### src/mask_block_bit_spender.sv
// Mask block bit spender: serves bit and byte requests from loaded mask
// block words. Every transaction yields one result, which passes the
// reservoir stage, fed by the registered read of the block word store (one
// write port, one read port), and then the result register before it is
// presented on the master side. A new transaction is taken every cycle as
// long as results are drained. Counters and reservoir fill levels update in
// the accept cycle, reservoir data later, in order, as the transaction
// leaves the reservoir stage, so no interlock is needed. The store needs no
// clearing after reset. block_words may only be written while no
// transaction is in flight; a write discards the current block and any
// partial fill but keeps both reservoirs.
module mask_block_bit_spender #(
  parameter int MAX_BLOCK_WORDS = mbbs_pkg::DEF_MAX_BLK_WORDS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [39:0]                s_axis_tdata,  // bit_count[5:0], block_word[37:6]
  input  logic [1:0]                 s_axis_tuser,  // kind[1:0]
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [39:0]                m_axis_tdata,  // value[31:0], status[33:32]
  input  logic                       cfg_we_i,
  input  logic [mbbs_pkg::CFG_W-1:0] cfg_wdata_i
);
  import mbbs_pkg::*;

  localparam int AddrW = (MAX_BLOCK_WORDS > 1) ? $clog2(MAX_BLOCK_WORDS) : 1;

  logic              acc;
  s2_op_t            op;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AddrW-1:0]  mem_raddr;
  logic [WORD_W-1:0] mem_rdata;
  logic [WORD_W-1:0] out_value;
  status_e           out_status;

  assign acc = s_axis_tvalid && s_axis_tready;

  mbbs_ctrl #(
    .MaxWords (MAX_BLOCK_WORDS),
    .AddrW    (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .kind_i      (s_axis_tuser),
    .need_i      (s_axis_tdata[5:0]),
    .word_i      (s_axis_tdata[37:6]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_o        (op),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr)
  );

  mbbs_store #(
    .Depth (MAX_BLOCK_WORDS),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  mbbs_drain u_drain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .op_i         (op),
    .rdata_i      (mem_rdata),
    .in_ready_o   (s_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_value_o  (out_value),
    .out_status_o (out_status)
  );

  assign m_axis_tdata = {6'd0, out_status, out_value};

endmodule
